>>> sv/lqmc_pkg.sv
// Shared constants, codes and payload types for the latency queue memory controller.
// No dependencies.
package lqmc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QOCC_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REL_W       = QPTR_W + 1;

   localparam logic [1:0] KIND_CORE = 2'd0;
   localparam logic [1:0] KIND_DRAM = 2'd1;
   localparam logic [1:0] KIND_STAT = 2'd2;

   localparam logic CSR_LATENCY = 1'b0;
   localparam logic CSR_POSTED  = 1'b1;

   typedef struct packed {
      logic        req_valid;
      logic        req_write;
      logic [31:0] req_addr;
      logic [3:0]  req_size;
      logic [63:0] req_wdata;
      logic [7:0]  req_id;
      logic        dram_resp_valid;
      logic [63:0] dram_resp_data;
      logic [7:0]  dram_resp_id;
      logic        dram_req_ready;
      logic [1:0]  core_resp_room;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [7:0]  tag;
      logic [63:0] data;
      logic [31:0] addr;
      logic [3:0]  size;
      logic        is_write;
      logic        req_taken;
      logic        dram_resp_taken;
      logic        stores_pending;
      logic        guard_fault;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] latency_cycles;
      logic       posted_stores;
   } cfg_type;

endpackage

>>> sv/lqmc_req_if.sv
// Input channel: one clock tick of core request, DRAM response and downstream room.
// Depends on nothing.
interface lqmc_req_if;
   logic        valid;
   logic        ready;
   logic        req_valid;
   logic        req_write;
   logic [31:0] req_addr;
   logic [3:0]  req_size;
   logic [63:0] req_wdata;
   logic [7:0]  req_id;
   logic        dram_resp_valid;
   logic [63:0] dram_resp_data;
   logic [7:0]  dram_resp_id;
   logic        dram_req_ready;
   logic [1:0]  core_resp_room;

   modport source (output valid, req_valid, req_write, req_addr, req_size, req_wdata, req_id,
                   dram_resp_valid, dram_resp_data, dram_resp_id, dram_req_ready,
                   core_resp_room, input ready);
   modport sink (input valid, req_valid, req_write, req_addr, req_size, req_wdata, req_id,
                 dram_resp_valid, dram_resp_data, dram_resp_id, dram_req_ready,
                 core_resp_room, output ready);
endinterface

>>> sv/lqmc_rsp_if.sv
// Result channel: core responses, DRAM requests and tick status.
// Depends on nothing.
interface lqmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        last;
   logic [7:0]  tag;
   logic [63:0] data;
   logic [31:0] addr;
   logic [3:0]  size;
   logic        is_write;
   logic        req_taken;
   logic        dram_resp_taken;
   logic        stores_pending;
   logic        guard_fault;

   modport source (output valid, kind, last, tag, data, addr, size, is_write, req_taken,
                   dram_resp_taken, stores_pending, guard_fault, input ready);
   modport sink (input valid, kind, last, tag, data, addr, size, is_write, req_taken,
                 dram_resp_taken, stores_pending, guard_fault, output ready);
endinterface

>>> sv/lqmc_front.sv
// Front end: two-entry input queue that decouples tick acceptance from execution.
// Depends on lqmc_pkg and lqmc_req_if.
module lqmc_front (
   input  logic                  clock,
   input  logic                  reset,
   lqmc_req_if.sink              req_if,
   output logic                  item_valid,
   output lqmc_pkg::req_item_type item,
   input  logic                  item_pop
);
   import lqmc_pkg::*;

   req_item_type slot_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   req_item_type in_item;

   assign req_if.ready = (count_ff != 2'd2);
   assign push = req_if.valid && req_if.ready;
   assign item_valid = (count_ff != 2'd0);
   assign item = slot_ff[rptr_ff];

   always_comb begin
      in_item.req_valid       = req_if.req_valid;
      in_item.req_write       = req_if.req_write;
      in_item.req_addr        = req_if.req_addr;
      in_item.req_size        = req_if.req_size;
      in_item.req_wdata       = req_if.req_wdata;
      in_item.req_id          = req_if.req_id;
      in_item.dram_resp_valid = req_if.dram_resp_valid;
      in_item.dram_resp_data  = req_if.dram_resp_data;
      in_item.dram_resp_id    = req_if.dram_resp_id;
      in_item.dram_req_ready  = req_if.dram_req_ready;
      in_item.core_resp_room  = req_if.core_resp_room;
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = item_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= in_item;
      end
   end
endmodule

>>> sv/lqmc_back.sv
// Back end: latency queue, aging, issue, forwarding and result sequencing.
// Depends on lqmc_pkg and lqmc_rsp_if.
module lqmc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lqmc_pkg::cfg_type     cfg,
   input  logic                  item_valid,
   input  lqmc_pkg::req_item_type item,
   output logic                  item_pop,
   lqmc_rsp_if.source            rsp_if
);
   import lqmc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AGE   = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DRAM  = 3'd3;
   localparam logic [2:0] ST_REQ   = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;
   localparam logic [2:0] ST_STAT  = 3'd6;

   logic        ent_write_ff [QUEUE_DEPTH];
   logic [31:0] ent_addr_ff  [QUEUE_DEPTH];
   logic [3:0]  ent_size_ff  [QUEUE_DEPTH];
   logic [63:0] ent_data_ff  [QUEUE_DEPTH];
   logic [7:0]  ent_tag_ff   [QUEUE_DEPTH];
   logic [7:0]  ent_cd_ff    [QUEUE_DEPTH];

   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QOCC_W-1:0] occ_ff, occ_in;
   logic [2:0]        state_ff, state_in;
   req_item_type      cur_ff, cur_in;
   logic [1:0]        room_ff, room_in;
   logic              taken_ff, taken_in;
   logic              rtaken_ff, rtaken_in;
   logic              fault_ff, fault_in;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_ff, out_in;

   logic              can_emit, emit, do_push, do_pop, do_age;
   rsp_item_type      emit_item;
   logic [QUEUE_DEPTH-1:0] occupied;
   logic              hit, pending, need_ack, aligned, head_ready;
   logic [63:0]       fwd_data;
   logic [32:0]       a0, a1;

   assign can_emit = !out_valid_ff || rsp_if.ready;

   always_comb begin
      logic [REL_W-1:0]  rel;
      logic [QPTR_W-1:0] s;
      logic [REL_W-1:0]  sum;
      logic [32:0]       b0, b1;
      occupied = '0;
      hit      = 1'b0;
      fwd_data = '0;
      pending  = 1'b0;
      a0 = {1'b0, cur_ff.req_addr};
      a1 = a0 + 33'(cur_ff.req_size);
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         rel = REL_W'(k) + REL_W'(QUEUE_DEPTH) - {1'b0, head_ff};
         if (rel >= REL_W'(QUEUE_DEPTH)) begin
            rel = rel - REL_W'(QUEUE_DEPTH);
         end
         occupied[k] = (QOCC_W'(rel) < occ_ff);
         if (occupied[k] && ent_write_ff[k]) begin
            pending = 1'b1;
         end
      end
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         sum = {1'b0, head_ff} + REL_W'(k);
         if (sum >= REL_W'(QUEUE_DEPTH)) begin
            sum = sum - REL_W'(QUEUE_DEPTH);
         end
         s = sum[QPTR_W-1:0];
         b0 = {1'b0, ent_addr_ff[s]};
         b1 = b0 + 33'(ent_size_ff[s]);
         if (occupied[s] && ent_write_ff[s] && cur_ff.req_size != 4'd0
             && !(a1 <= b0 || b1 <= a0)) begin
            hit      = 1'b1;
            fwd_data = ent_data_ff[s];
         end
      end
   end

   assign aligned    = (cur_ff.req_size == 4'd8) && (cur_ff.req_addr[2:0] == 3'd0);
   assign need_ack   = ent_write_ff[head_ff] && !cfg.posted_stores;
   assign head_ready = (occ_ff != '0) && (ent_cd_ff[head_ff] == 8'd0);

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      room_in   = room_ff;
      taken_in  = taken_ff;
      rtaken_in = rtaken_ff;
      fault_in  = fault_ff;
      item_pop  = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_age    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop  = 1'b1;
               cur_in    = item;
               room_in   = item.core_resp_room;
               taken_in  = 1'b0;
               rtaken_in = 1'b0;
               fault_in  = 1'b0;
               state_in  = ST_AGE;
            end
         end
         ST_AGE: begin
            do_age   = 1'b1;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (head_ready && cur_ff.dram_req_ready && (!need_ack || room_ff != 2'd0)) begin
               if (need_ack) begin
                  if (can_emit) begin
                     emit           = 1'b1;
                     emit_item.kind = KIND_CORE;
                     emit_item.tag  = ent_tag_ff[head_ff];
                     room_in        = room_ff - 2'd1;
                     state_in       = ST_DRAM;
                  end
               end else begin
                  state_in = ST_DRAM;
               end
            end else begin
               state_in = ST_REQ;
            end
         end
         ST_DRAM: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_item.kind     = KIND_DRAM;
               emit_item.tag      = ent_tag_ff[head_ff];
               emit_item.data     = ent_data_ff[head_ff];
               emit_item.addr     = ent_addr_ff[head_ff];
               emit_item.size     = ent_size_ff[head_ff];
               emit_item.is_write = ent_write_ff[head_ff];
               do_pop             = 1'b1;
               state_in           = ST_REQ;
            end
         end
         ST_REQ: begin
            if (cur_ff.req_valid && room_ff != 2'd0 && occ_ff < QOCC_W'(QUEUE_DEPTH)) begin
               priority if (cur_ff.req_write && !cfg.posted_stores) begin
                  taken_in = 1'b1;
                  do_push  = 1'b1;
                  state_in = ST_RESP;
               end else if (can_emit) begin
                  taken_in       = 1'b1;
                  emit           = 1'b1;
                  emit_item.kind = KIND_CORE;
                  emit_item.tag  = cur_ff.req_id;
                  room_in        = room_ff - 2'd1;
                  fault_in       = !aligned;
                  state_in       = ST_RESP;
                  if (cur_ff.req_write) begin
                     do_push = 1'b1;
                  end else begin
                     emit_item.data = fwd_data;
                  end
               end else if (!cur_ff.req_write && !hit) begin
                  taken_in = 1'b1;
                  do_push  = 1'b1;
                  state_in = ST_RESP;
               end
               if (!cur_ff.req_write && !hit) begin
                  emit     = 1'b0;
                  room_in  = room_ff;
                  fault_in = 1'b0;
                  do_push  = 1'b1;
                  taken_in = 1'b1;
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (cur_ff.dram_resp_valid && room_ff != 2'd0) begin
               if (can_emit) begin
                  emit           = 1'b1;
                  emit_item.kind = KIND_CORE;
                  emit_item.tag  = cur_ff.dram_resp_id;
                  emit_item.data = cur_ff.dram_resp_data;
                  room_in        = room_ff - 2'd1;
                  rtaken_in      = 1'b1;
                  state_in       = ST_STAT;
               end
            end else begin
               state_in = ST_STAT;
            end
         end
         ST_STAT: begin
            if (can_emit) begin
               emit                      = 1'b1;
               emit_item.kind            = KIND_STAT;
               emit_item.last            = 1'b1;
               emit_item.req_taken       = taken_ff;
               emit_item.dram_resp_taken = rtaken_ff;
               emit_item.stores_pending  = pending;
               emit_item.guard_fault     = fault_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = emit || (out_valid_ff && !rsp_if.ready);
      out_in       = emit ? emit_item : out_ff;
      head_in = do_pop ? ((head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1) : head_ff;
      tail_in = do_push ? ((tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1)
                        : tail_ff;
      occ_in  = occ_ff + QOCC_W'(do_push) - QOCC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff    <= cur_in;
      room_ff   <= room_in;
      taken_ff  <= taken_in;
      rtaken_ff <= rtaken_in;
      fault_ff  <= fault_in;
      out_ff    <= out_in;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (do_age && occupied[k] && ent_cd_ff[k] != 8'd0) begin
            ent_cd_ff[k] <= ent_cd_ff[k] - 8'd1;
         end
      end
      if (do_push) begin
         ent_write_ff[tail_ff] <= cur_ff.req_write;
         ent_addr_ff[tail_ff]  <= cur_ff.req_addr;
         ent_size_ff[tail_ff]  <= cur_ff.req_size;
         ent_data_ff[tail_ff]  <= cur_ff.req_write ? cur_ff.req_wdata : 64'd0;
         ent_tag_ff[tail_ff]   <= cur_ff.req_id;
         ent_cd_ff[tail_ff]    <= cfg.latency_cycles;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.kind            = out_ff.kind;
   assign rsp_if.last            = out_ff.last;
   assign rsp_if.tag             = out_ff.tag;
   assign rsp_if.data            = out_ff.data;
   assign rsp_if.addr            = out_ff.addr;
   assign rsp_if.size            = out_ff.size;
   assign rsp_if.is_write        = out_ff.is_write;
   assign rsp_if.req_taken       = out_ff.req_taken;
   assign rsp_if.dram_resp_taken = out_ff.dram_resp_taken;
   assign rsp_if.stores_pending  = out_ff.stores_pending;
   assign rsp_if.guard_fault     = out_ff.guard_fault;
endmodule

>>> sv/latency_queue_mem_ctrl.sv
// Latency queue memory controller: configuration registers, front queue and back end.
// Depends on lqmc_pkg, lqmc_req_if, lqmc_rsp_if, lqmc_front and lqmc_back.
// Sequencing: the back end takes one tick from the front queue at a time, stepping
// through its idle, age, issue, DRAM (only when the head issues), request, response
// and status states; a result register waiting on rsp_if.ready holds the sequencer.
// Reset: synchronous; empties the queue and output, latency_cycles 10, posted_stores 0.
module latency_queue_mem_ctrl (
   input  logic       clock,
   input  logic       reset,
   lqmc_req_if.sink   req_if,
   lqmc_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import lqmc_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         item_valid;
   logic         item_pop;
   req_item_type item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LATENCY: cfg_in.latency_cycles = csr_wdata;
            CSR_POSTED:  cfg_in.posted_stores  = csr_wdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latency_cycles <= 8'd10;
         cfg_ff.posted_stores  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lqmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   lqmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_if     (rsp_if)
   );
endmodule

>>> dv/tb_latency_queue_mem_ctrl.sv
// Testbench for the latency queue memory controller: drives clock ticks over the request
// interface, predicts every core response, DRAM request and status, and checks each transfer.
// Depends on lqmc_pkg, lqmc_req_if, lqmc_rsp_if and latency_queue_mem_ctrl.
module tb_latency_queue_mem_ctrl;
   import lqmc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_LATENCY;
   logic [7:0] csr_wdata = '0;

   lqmc_req_if req_if ();
   lqmc_rsp_if rsp_if ();

   latency_queue_mem_ctrl uut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic        q_write [QUEUE_DEPTH];
   logic [31:0] q_addr [QUEUE_DEPTH];
   logic [3:0]  q_size [QUEUE_DEPTH];
   logic [63:0] q_data [QUEUE_DEPTH];
   logic [7:0]  q_tag [QUEUE_DEPTH];
   logic [7:0]  q_count [QUEUE_DEPTH];
   int          q_head, q_tail, q_occ;
   logic [7:0]  lat_cfg;
   logic        posted_cfg;

   rsp_item_type exp_mem [int];
   int  exp_wr = 0;
   int  exp_rd = 0;
   int  errors = 0;
   int  cycles = 0;
   bit  idle_enable = 1'b1;
   int  hold_rsp = 0;
   logic [31:0] addr_pool[4] = '{32'h0000_1000, 32'h0000_1008, 32'hFFFF_FFF8, 32'h0000_0000};

   function automatic rsp_item_type blank_rsp(logic [1:0] k);
      rsp_item_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic bit aligned8(logic [31:0] a, logic [3:0] s);
      return s == 4'd8 && a[2:0] == 3'd0;
   endfunction

   function automatic void add_expected(input rsp_item_type r);
      exp_mem[exp_wr] = r;
      exp_wr++;
   endfunction

   task automatic predict_tick(input req_item_type t);
      int unsigned room;
      int s, k;
      bit taken, rtaken, fault, pending, hit, need_ack;
      logic [63:0] fwd;
      logic [32:0] a0, a1, b0, b1;
      rsp_item_type r;
      room = t.core_resp_room;
      taken = 0; rtaken = 0; fault = 0; pending = 0;
      for (k = 0; k < q_occ; k++) begin
         s = (q_head + k) % QUEUE_DEPTH;
         if (q_count[s] != 0) q_count[s]--;
      end
      if (q_occ > 0 && q_count[q_head] == 0) begin
         need_ack = q_write[q_head] && !posted_cfg;
         if (t.dram_req_ready && (!need_ack || room > 0)) begin
            if (need_ack) begin
               r = blank_rsp(KIND_CORE);
               r.tag = q_tag[q_head];
               add_expected(r);
               room--;
            end
            r = blank_rsp(KIND_DRAM);
            r.tag = q_tag[q_head];
            r.data = q_data[q_head];
            r.addr = q_addr[q_head];
            r.size = q_size[q_head];
            r.is_write = q_write[q_head];
            add_expected(r);
            q_head = (q_head + 1) % QUEUE_DEPTH;
            q_occ--;
         end
      end
      if (t.req_valid && room > 0 && q_occ < QUEUE_DEPTH) begin
         taken = 1;
         hit = 0;
         fwd = '0;
         if (!t.req_write && t.req_size != 0) begin
            a0 = {1'b0, t.req_addr};
            a1 = a0 + t.req_size;
            for (k = q_occ; k > 0 && !hit; k--) begin
               s = (q_head + k - 1) % QUEUE_DEPTH;
               if (q_write[s]) begin
                  b0 = {1'b0, q_addr[s]};
                  b1 = b0 + q_size[s];
                  if (!(a1 <= b0 || b1 <= a0)) begin
                     hit = 1;
                     fwd = q_data[s];
                  end
               end
            end
         end
         if ((t.req_write && posted_cfg) || hit) begin
            if (!aligned8(t.req_addr, t.req_size)) fault = 1;
            r = blank_rsp(KIND_CORE);
            r.tag = t.req_id;
            r.data = hit ? fwd : 64'd0;
            add_expected(r);
            room--;
         end
         if (!hit) begin
            q_write[q_tail] = t.req_write;
            q_addr[q_tail] = t.req_addr;
            q_size[q_tail] = t.req_size;
            q_data[q_tail] = t.req_write ? t.req_wdata : 64'd0;
            q_tag[q_tail] = t.req_id;
            q_count[q_tail] = lat_cfg;
            q_tail = (q_tail + 1) % QUEUE_DEPTH;
            q_occ++;
         end
      end
      if (t.dram_resp_valid && room > 0) begin
         rtaken = 1;
         r = blank_rsp(KIND_CORE);
         r.tag = t.dram_resp_id;
         r.data = t.dram_resp_data;
         add_expected(r);
      end
      for (k = 0; k < q_occ; k++)
         if (q_write[(q_head + k) % QUEUE_DEPTH]) pending = 1;
      r = blank_rsp(KIND_STAT);
      r.last = 1'b1;
      r.req_taken = taken;
      r.dram_resp_taken = rtaken;
      r.stores_pending = pending;
      r.guard_fault = fault;
      add_expected(r);
   endtask

   task automatic send_tick(input req_item_type t);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_valid <= t.req_valid;
      req_if.req_write <= t.req_write;
      req_if.req_addr <= t.req_addr;
      req_if.req_size <= t.req_size;
      req_if.req_wdata <= t.req_wdata;
      req_if.req_id <= t.req_id;
      req_if.dram_resp_valid <= t.dram_resp_valid;
      req_if.dram_resp_data <= t.dram_resp_data;
      req_if.dram_resp_id <= t.dram_resp_id;
      req_if.dram_req_ready <= t.dram_req_ready;
      req_if.core_resp_room <= t.core_resp_room;
      do @(posedge clock); while (!req_if.ready);
      predict_tick(t);
   endtask

   function automatic req_item_type rand_tick(bit shaped);
      req_item_type t;
      t = '0;
      t.req_valid = $urandom_range(0, 3) != 0;
      t.req_write = 1'($urandom_range(0, 1));
      if (shaped) begin
         t.req_addr = addr_pool[$urandom_range(0, 3)] + ($urandom_range(0, 3) == 0 ?
                      32'($urandom_range(0, 7)) : 32'd0);
         t.req_size = $urandom_range(0, 4) == 0 ? 4'($urandom_range(0, 15)) : 4'd8;
      end else begin
         t.req_addr = $urandom;
         t.req_size = 4'($urandom_range(0, 15));
      end
      t.req_wdata = {$urandom, $urandom};
      t.req_id = 8'($urandom);
      t.dram_resp_valid = $urandom_range(0, 2) == 0;
      t.dram_resp_data = {$urandom, $urandom};
      t.dram_resp_id = 8'($urandom);
      t.dram_req_ready = $urandom_range(0, 3) != 0;
      t.core_resp_room = 2'($urandom_range(0, 3));
      return t;
   endfunction

   task automatic drain();
      req_if.valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LATENCY) lat_cfg = val;
      else posted_cfg = val[0];
      @(posedge clock);
   endtask

   task automatic test_directed();
      req_item_type t;
      int i;
      write_csr(CSR_LATENCY, 8'd0);
      write_csr(CSR_POSTED, 8'd0);
      t = '0;
      t.dram_req_ready = 1'b1; t.core_resp_room = 2'd3;
      t.req_valid = 1'b1; t.req_write = 1'b1; t.req_addr = 32'hFFFF_FFF8;
      t.req_size = 4'd8; t.req_wdata = '1; t.req_id = 8'hFF;
      send_tick(t);
      t.req_write = 1'b0; t.req_addr = 32'hFFFF_FFFC; t.req_size = 4'd4; t.req_id = 8'h01;
      send_tick(t);
      t.req_size = 4'd0; t.req_id = 8'h02;
      send_tick(t);
      t.req_valid = 1'b0; t.dram_resp_valid = 1'b1; t.dram_resp_data = '1;
      t.dram_resp_id = 8'hFF;
      send_tick(t);
      t.dram_resp_data = '0; t.dram_resp_id = 8'h00; t.core_resp_room = 2'd0;
      send_tick(t);
      t.dram_resp_valid = 1'b0; t.core_resp_room = 2'd3;
      for (i = 0; i < 6; i++) send_tick(t);
      drain();
      write_csr(CSR_POSTED, 8'd1);
      write_csr(CSR_LATENCY, 8'd255);
      t = '0;
      t.core_resp_room = 2'd3; t.req_valid = 1'b1; t.req_write = 1'b1;
      t.req_addr = 32'h0000_0003; t.req_size = 4'd15; t.req_wdata = 64'h0123_4567_89AB_CDEF;
      t.req_id = 8'h10;
      send_tick(t);
      t.req_addr = 32'h0000_0008; t.req_size = 4'd8; t.req_id = 8'h11;
      send_tick(t);
      t.req_write = 1'b0; t.req_addr = 32'h0000_0008; t.req_size = 4'd8; t.req_id = 8'h12;
      send_tick(t);
      t.req_addr = 32'h0000_0001; t.req_size = 4'd2; t.req_id = 8'h13;
      send_tick(t);
      t.req_addr = 32'h0000_0100; t.req_size = 4'd8; t.req_id = 8'h14;
      send_tick(t);
      for (i = 0; i < 16; i++) begin
         t.req_id = 8'(i + 32);
         t.req_addr = 32'h0000_0200 + 32'(i * 8);
         send_tick(t);
      end
      drain();
      write_csr(CSR_LATENCY, 8'd0);
      t.req_valid = 1'b0; t.dram_req_ready = 1'b1;
      while (q_occ != 0) send_tick(t);
      drain();
   endtask

   task automatic test_random(input int count, input logic [7:0] lat, input logic posted);
      int i;
      write_csr(CSR_LATENCY, lat);
      write_csr(CSR_POSTED, {7'd0, posted});
      for (i = 0; i < count; i++) send_tick(rand_tick($urandom_range(0, 4) != 0));
      drain();
   endtask

   task automatic test_backpressure();
      int i;
      write_csr(CSR_LATENCY, 8'd3);
      write_csr(CSR_POSTED, 8'd0);
      hold_rsp = 150;
      for (i = 0; i < 40; i++) send_tick(rand_tick(1'b1));
      drain();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.req_valid = 1'b0; req_if.req_write = 1'b0; req_if.req_addr = '0;
      req_if.req_size = '0; req_if.req_wdata = '0; req_if.req_id = '0;
      req_if.dram_resp_valid = 1'b0; req_if.dram_resp_data = '0; req_if.dram_resp_id = '0;
      req_if.dram_req_ready = 1'b0; req_if.core_resp_room = '0;
      q_head = 0; q_tail = 0; q_occ = 0;
      lat_cfg = 8'd10; posted_cfg = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(40, 8'd10, 1'b0);
      test_backpressure();
      test_random(40, 8'd1, 1'b1);
      test_random(20, 8'd255, 1'b0);
      idle_enable = 1'b0;
      test_random(60, 8'd2, 1'b0);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // long receiver hold when requested, otherwise bursty stalls while idles are enabled
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_rsp) @(posedge clock);
            hold_rsp = 0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      cycles++;
      if (cycles > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (exp_wr == exp_rd) begin
            $error("unexpected result transfer kind %0d tag %0h", rsp_if.kind, rsp_if.tag);
            errors++;
         end else begin
            want = exp_mem[exp_rd];
            exp_mem.delete(exp_rd);
            exp_rd++;
            if (rsp_if.kind !== want.kind) begin
               $error("kind expected %0d actual %0d", want.kind, rsp_if.kind); errors++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_if.last); errors++;
            end
            if (rsp_if.tag !== want.tag) begin
               $error("tag expected %0h actual %0h", want.tag, rsp_if.tag); errors++;
            end
            if (rsp_if.data !== want.data) begin
               $error("data expected %0h actual %0h", want.data, rsp_if.data); errors++;
            end
            if (rsp_if.addr !== want.addr) begin
               $error("addr expected %0h actual %0h", want.addr, rsp_if.addr); errors++;
            end
            if (rsp_if.size !== want.size) begin
               $error("size expected %0d actual %0d", want.size, rsp_if.size); errors++;
            end
            if (rsp_if.is_write !== want.is_write) begin
               $error("is_write expected %0d actual %0d", want.is_write, rsp_if.is_write);
               errors++;
            end
            if (rsp_if.req_taken !== want.req_taken) begin
               $error("req_taken expected %0d actual %0d", want.req_taken, rsp_if.req_taken);
               errors++;
            end
            if (rsp_if.dram_resp_taken !== want.dram_resp_taken) begin
               $error("dram_resp_taken expected %0d actual %0d", want.dram_resp_taken,
                      rsp_if.dram_resp_taken);
               errors++;
            end
            if (rsp_if.stores_pending !== want.stores_pending) begin
               $error("stores_pending expected %0d actual %0d", want.stores_pending,
                      rsp_if.stores_pending);
               errors++;
            end
            if (rsp_if.guard_fault !== want.guard_fault) begin
               $error("guard_fault expected %0d actual %0d", want.guard_fault,
                      rsp_if.guard_fault);
               errors++;
            end
         end
      end
   end
endmodule

>>> sim.f
sv/lqmc_pkg.sv
sv/lqmc_req_if.sv
sv/lqmc_rsp_if.sv
sv/lqmc_front.sv
sv/lqmc_back.sv
sv/latency_queue_mem_ctrl.sv
dv/tb_latency_queue_mem_ctrl.sv
